>>> rtl/core/skr_pkg.sv
// ----------------------------------------------------------------------------
// skr_pkg
// constants and helpers shared by the seed/key shift register cells and top
// ----------------------------------------------------------------------------
package skr_pkg;

  localparam int unsigned KEY_W       = 24;
  localparam int unsigned CHAL_W      = 64;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned HI_BYTES_W  = 40;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [CHAL_W-1:0]  chal_t;
  typedef logic [LEVEL_W-1:0] level_t;

  localparam key_t KEY_INIT = 24'hC541A9;
  localparam key_t KEY_TAPS = 24'h109028;

  // access levels that replace challenge bytes 3..7
  localparam level_t LEVEL_A = 8'h01;
  localparam level_t LEVEL_B = 8'h03;
  localparam level_t LEVEL_C = 8'h61;

  // bytes 7..3, most significant first
  localparam logic [HI_BYTES_W-1:0] HI_BYTES_A = 40'h6E61776F52;
  localparam logic [HI_BYTES_W-1:0] HI_BYTES_B = 40'h7241E4895A;
  localparam logic [HI_BYTES_W-1:0] HI_BYTES_C = 40'h3868045A4D;

  function automatic chal_t substitute_bytes(input level_t level, input chal_t chal);
    chal_t res;
    res = chal;
    case (level)
      LEVEL_A: res[CHAL_W-1:KEY_W] = HI_BYTES_A;
      LEVEL_B: res[CHAL_W-1:KEY_W] = HI_BYTES_B;
      LEVEL_C: res[CHAL_W-1:KEY_W] = HI_BYTES_C;
      default: res = chal;
    endcase
    return res;
  endfunction

  function automatic key_t permute_nibbles(input key_t r);
    key_t k;
    k[7:0]   = {r[11:8], r[7:4]};
    k[15:8]  = {r[15:12], r[23:20]};
    k[23:16] = {r[3:0], r[19:16]};
    return k;
  endfunction

endpackage

>>> rtl/core/skr_cell.sv
// ----------------------------------------------------------------------------
// skr_cell
// one link of the chain: runs STEPS shift register steps and registers them
// ----------------------------------------------------------------------------
module skr_cell
  import skr_pkg::*;
#(
  parameter int unsigned STEPS = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  key_t  in_state,
  input  chal_t in_bits,
  output logic  out_valid,
  input  logic  out_ready,
  output key_t  out_state,
  output chal_t out_bits
);

  logic  valid_r;
  key_t  state_r;
  chal_t bits_r;
  key_t  state_nxt;
  chal_t bits_nxt;

  always_comb begin
    logic fb;
    state_nxt = in_state;
    for (int unsigned i = 0; i < STEPS; i++) begin
      fb = in_bits[i] ^ state_nxt[0];
      state_nxt = {fb, state_nxt[KEY_W-1:1]};
      if (fb) begin
        state_nxt = state_nxt ^ KEY_TAPS;
      end
    end
    bits_nxt = in_bits >> STEPS;
  end

  // a cell takes a new transaction when empty or when its own is moving on
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      state_r <= state_nxt;
      bits_r  <= bits_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_state = state_r;
  assign out_bits  = bits_r;

endmodule

>>> rtl/core/seed_key_shift_register.sv
// ----------------------------------------------------------------------------
// seed_key_shift_register
// 24-bit security-access key from an access level and a 64-bit challenge
// ----------------------------------------------------------------------------
// The 64 register steps are spread over a chain of 64/CELL_STEPS cells, each
// doing CELL_STEPS steps and holding its transaction in a register. A new
// transaction is accepted every cycle while in_ready is high, and each key
// passes through the register of every cell in the chain, in chain order.
// The last cell's register is the output register, so a stalled key only
// holds back the cells behind it and empty cells still fill. CELL_STEPS must
// divide 64.
// ----------------------------------------------------------------------------
module seed_key_shift_register
  import skr_pkg::*;
#(
  parameter int unsigned CELL_STEPS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_access_level,
  input  logic [63:0] in_challenge,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_key
);

  localparam int unsigned NUM_CELLS = CHAL_W / CELL_STEPS;

  logic  valid_c [0:NUM_CELLS];
  logic  ready_c [0:NUM_CELLS];
  key_t  state_c [0:NUM_CELLS];
  chal_t bits_c  [0:NUM_CELLS];

  assign valid_c[0] = in_valid;
  assign in_ready   = ready_c[0];
  assign state_c[0] = KEY_INIT;
  assign bits_c[0]  = substitute_bytes(in_access_level, in_challenge);

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    skr_cell #(
      .STEPS(CELL_STEPS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (valid_c[g]),
      .in_ready (ready_c[g]),
      .in_state (state_c[g]),
      .in_bits  (bits_c[g]),
      .out_valid(valid_c[g+1]),
      .out_ready(ready_c[g+1]),
      .out_state(state_c[g+1]),
      .out_bits (bits_c[g+1])
    );
  end

  assign ready_c[NUM_CELLS] = out_ready;
  assign out_valid          = valid_c[NUM_CELLS];
  assign out_key            = permute_nibbles(state_c[NUM_CELLS]);

endmodule
